>>> design/process_table_mlfq_levels_assert.svh
// Assertion macros for the process table block
`ifndef PROCESS_TABLE_MLFQ_LEVELS_ASSERT_SVH
`define PROCESS_TABLE_MLFQ_LEVELS_ASSERT_SVH

`define PTM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define PTM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/ptm_pkg.sv
package ptm_pkg;

   localparam int unsigned DEF_SLOTS  = 16;
   localparam int unsigned DEF_LEVELS = 5;
   localparam int unsigned MAX_LEVELS = 5;
   localparam int unsigned RT_W       = 48;
   localparam int unsigned NUM_REGS   = 8;

   localparam logic [2:0] FN_ALLOC    = 3'd0;
   localparam logic [2:0] FN_FREE     = 3'd1;
   localparam logic [2:0] FN_FREE_ALL = 3'd2;
   localparam logic [2:0] FN_SET      = 3'd3;
   localparam logic [2:0] FN_CHARGE   = 3'd4;
   localparam logic [2:0] FN_TICK     = 3'd5;

   localparam logic [2:0] ST_UNUSED  = 3'd0;
   localparam logic [2:0] ST_LOADING = 3'd1;
   localparam logic [2:0] ST_MAX     = 3'd5;

   localparam logic [1:0] RC_OK     = 2'd0;
   localparam logic [1:0] RC_FULL   = 2'd1;
   localparam logic [1:0] RC_NOTFND = 2'd2;
   localparam logic [1:0] RC_NOPID  = 2'd3;

   localparam logic [2:0] REG_Q0    = 3'd0;
   localparam logic [2:0] REG_Q1    = 3'd1;
   localparam logic [2:0] REG_Q2    = 3'd2;
   localparam logic [2:0] REG_Q3    = 3'd3;
   localparam logic [2:0] REG_Q4    = 3'd4;
   localparam logic [2:0] REG_BOOST = 3'd5;
   localparam logic [2:0] REG_SHELL = 3'd6;
   localparam logic [2:0] REG_USER  = 3'd7;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] target_pid;
      logic [2:0]  new_status;
      logic [31:0] run_time;
      logic [63:0] now_time;
      logic        key_pending;
   } req_type;

   typedef struct packed {
      logic [15:0] result_pid;
      logic [1:0]  result_code;
      logic [2:0]  result_level;
      logic        boost_done;
   } rsp_type;

   // one slot record as it travels along the chain
   typedef struct packed {
      logic [15:0]     pid;
      logic [2:0]      status;
      logic [2:0]      level;
      logic [RT_W-1:0] runtime;
   } slot_type;

   // operation applied by the head logic for one pass
   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] pid;
      logic [2:0]  new_status;
      logic        boost;
      logic        key;
      logic [15:0] shell_pid;
      logic [15:0] user_pid;
   } op_type;

endpackage

>>> design/process_table_mlfq_levels.sv
// Channel  Ports          Direction  Payload
// req      req_valid/rdy  in         ptm_pkg::req_type
// rsp      rsp_valid/rdy  out        ptm_pkg::rsp_type
// csr      APB (psel..)   in/out     32-bit registers at 4*i
// An item passes IDLE, where it is accepted, RUN, which rotates the slot
// records once round the chain, and DONE, which loads the result.
// A charge holds the ring while the charged record can still climb a level.
// Synchronous active-high reset empties the table and restores registers.
// The next item may run while a result waits; its own result then holds in
// DONE until rsp_ready frees the result register.
module process_table_mlfq_levels #(
   parameter int unsigned SLOTS  = ptm_pkg::DEF_SLOTS,
   parameter int unsigned LEVELS = ptm_pkg::DEF_LEVELS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptm_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import ptm_pkg::*;

   localparam int unsigned CW = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff;
   op_type op_ff;
   logic [31:0] rt_ff;
   logic [31:0] quantum_ff [MAX_LEVELS];
   logic [31:0] boost_period_ff;
   logic [15:0] shell_pid_ff, user_pid_ff;
   logic [15:0] last_pid_ff;
   logic [63:0] last_boost_ff;
   logic done_ff;
   logic nopid_ff;
   logic [2:0] level_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic prom_ff;
   slot_type prom_rec_ff;

   slot_type chain [SLOTS+1];
   slot_type head_out;
   logic hit, more, stall, shift, accept, wr;
   logic rsp_free, load_rsp;
   logic [2:0] ridx;
   logic [63:0] elapsed;
   logic boost_now;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign stall = (state_ff == S_RUN) && hit && more;
   assign shift = (state_ff == S_RUN) && !stall;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign load_rsp = (state_ff == S_DONE) && rsp_free;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign ridx = paddr[4:2];
   assign elapsed = req_data.now_time - last_boost_ff;
   assign boost_now = (last_boost_ff != '0) && (elapsed >= {32'd0, boost_period_ff});

   assign chain[0] = head_out;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ptm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d_in  (chain[g]),
         .q_out (chain[g+1])
      );
   end

   ptm_head #(.LEVELS(LEVELS)) u_head (
      .op         (op_ff),
      .rec_in     (chain[SLOTS]),
      .done_ff    (done_ff),
      .new_pid_ok (last_pid_ff != 16'hFFFF),
      .new_pid    (last_pid_ff + 16'd1),
      .run_time   (rt_ff),
      .quantum    (quantum_ff),
      .prom_busy  (prom_ff),
      .prom_rec   (prom_rec_ff),
      .rec_out    (head_out),
      .hit        (hit),
      .more       (more)
   );

   always_comb begin
      case (ridx)
         REG_Q0:    prdata = quantum_ff[0];
         REG_Q1:    prdata = quantum_ff[1];
         REG_Q2:    prdata = quantum_ff[2];
         REG_Q3:    prdata = quantum_ff[3];
         REG_Q4:    prdata = quantum_ff[4];
         REG_BOOST: prdata = boost_period_ff;
         REG_SHELL: prdata = {16'd0, shell_pid_ff};
         REG_USER:  prdata = {16'd0, user_pid_ff};
         default:   prdata = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_RUN;
         S_RUN:   if (shift && cnt_ff == CW'(SLOTS - 1)) state_in = S_DONE;
         S_DONE:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      case (op_ff.func)
         FN_ALLOC: begin
            if (!done_ff) rsp_in.result_code = RC_FULL;
            else if (nopid_ff) rsp_in.result_code = RC_NOPID;
            else rsp_in.result_pid = last_pid_ff;
         end
         FN_FREE, FN_SET, FN_CHARGE: begin
            rsp_in.result_pid = op_ff.pid;
            if (done_ff) rsp_in.result_level = level_ff;
            else rsp_in.result_code = RC_NOTFND;
         end
         FN_TICK: rsp_in.boost_done = op_ff.boost;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         quantum_ff[0] <= 32'd100000;
         quantum_ff[1] <= 32'd200000;
         quantum_ff[2] <= 32'd300000;
         quantum_ff[3] <= 32'd400000;
         quantum_ff[4] <= 32'd500000;
         boost_period_ff <= 32'd10000000;
         shell_pid_ff <= 16'd1;
         user_pid_ff <= 16'd3;
         last_pid_ff <= '0;
         last_boost_ff <= '0;
         done_ff <= 1'b0;
         prom_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prom_ff <= stall;
         if (wr) begin
            case (ridx)
               REG_Q0:    quantum_ff[0] <= pwdata;
               REG_Q1:    quantum_ff[1] <= pwdata;
               REG_Q2:    quantum_ff[2] <= pwdata;
               REG_Q3:    quantum_ff[3] <= pwdata;
               REG_Q4:    quantum_ff[4] <= pwdata;
               REG_BOOST: boost_period_ff <= pwdata;
               REG_SHELL: shell_pid_ff <= pwdata[15:0];
               REG_USER:  user_pid_ff <= pwdata[15:0];
               default: ;
            endcase
         end
         if (accept) begin
            cnt_ff <= '0;
            done_ff <= 1'b0;
            if (req_data.func == FN_TICK) begin
               if (last_boost_ff == '0 || boost_now) last_boost_ff <= req_data.now_time;
            end
         end
         if (shift) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (hit) begin
               done_ff <= 1'b1;
               if (op_ff.func == FN_ALLOC && last_pid_ff != 16'hFFFF)
                  last_pid_ff <= last_pid_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff.func <= req_data.func;
         op_ff.pid <= req_data.target_pid;
         op_ff.new_status <= req_data.new_status;
         op_ff.boost <= boost_now;
         op_ff.key <= req_data.key_pending;
         op_ff.shell_pid <= shell_pid_ff;
         op_ff.user_pid <= user_pid_ff;
         rt_ff <= req_data.run_time;
         level_ff <= '0;
         nopid_ff <= (last_pid_ff == 16'hFFFF);
      end
      if (shift && hit) level_ff <= head_out.level;
      if (stall) prom_rec_ff <= head_out;
      if (load_rsp) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

>>> design/ptm_cell.sv
// One slot of the ring. During a pass every cell hands its record to the
// next one; cell 0 receives the edited record from the head logic.
module ptm_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  ptm_pkg::slot_type d_in,
   output ptm_pkg::slot_type q_out
);
   import ptm_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (shift) begin
         slot_ff <= d_in;
      end
   end

   assign q_out = slot_ff;

endmodule

>>> design/ptm_head.sv
// Edits the record leaving the last cell before it re-enters cell 0.
// Tracks first-match; a charged record climbs one level per cycle while the
// ring holds, its partial result parked in the caller's promotion register.
module ptm_head #(
   parameter int unsigned LEVELS = ptm_pkg::DEF_LEVELS
) (
   input  ptm_pkg::op_type   op,
   input  ptm_pkg::slot_type rec_in,
   input  logic              done_ff,
   input  logic              new_pid_ok,
   input  logic [15:0]       new_pid,
   input  logic [31:0]       run_time,
   input  logic [31:0]       quantum [ptm_pkg::MAX_LEVELS],
   input  logic              prom_busy,
   input  ptm_pkg::slot_type prom_rec,
   output ptm_pkg::slot_type rec_out,
   output logic              hit,
   output logic              more
);
   import ptm_pkg::*;

   logic live;
   logic [RT_W:0] sum;
   logic [RT_W:0] diff;
   logic [31:0] q;
   logic can;
   slot_type work;

   always_comb begin
      rec_out = rec_in;
      live = (rec_in.status != ST_UNUSED);
      hit = 1'b0;
      more = 1'b0;
      sum = '0;
      diff = '0;
      q = '0;
      can = 1'b0;
      work = rec_in;
      case (op.func)
         FN_ALLOC: begin
            hit = !live && !done_ff;
            if (hit && new_pid_ok) begin
               rec_out.pid = new_pid;
               rec_out.status = ST_LOADING;
               rec_out.level = '0;
               rec_out.runtime = '0;
            end
         end
         FN_FREE, FN_SET, FN_CHARGE: begin
            hit = live && rec_in.pid == op.pid && !done_ff;
            if (hit) begin
               if (op.func == FN_FREE) begin
                  rec_out.status = ST_UNUSED;
               end else if (op.func == FN_SET) begin
                  if (op.new_status <= ST_MAX) rec_out.status = op.new_status;
               end else begin
                  // first cycle adds and saturates, later ones work on the parked copy
                  if (prom_busy) begin
                     work = prom_rec;
                  end else begin
                     sum = {1'b0, rec_in.runtime} + {{(RT_W-31){1'b0}}, run_time};
                     work.runtime = sum[RT_W] ? {RT_W{1'b1}} : sum[RT_W-1:0];
                  end
                  q = (work.level < 3'(MAX_LEVELS)) ? quantum[work.level] : '0;
                  diff = {1'b0, work.runtime} - {{(RT_W-31){1'b0}}, q};
                  can = (work.level < 3'(LEVELS - 1)) && !diff[RT_W];
                  rec_out = work;
                  if (can) begin
                     rec_out.level = work.level + 3'd1;
                     rec_out.runtime = diff[RT_W-1:0];
                  end
                  more = can && (rec_out.level < 3'(LEVELS - 1));
               end
            end
         end
         FN_FREE_ALL: begin
            if (live && rec_in.pid >= op.user_pid) rec_out.status = ST_UNUSED;
         end
         FN_TICK: begin
            hit = op.key && live && rec_in.pid == op.shell_pid && !done_ff;
            if (hit || (op.boost && live)) begin
               rec_out.level = '0;
               rec_out.runtime = '0;
            end
         end
         default: ;
      endcase
   end

endmodule

>>> design/ptm_checker.sv
module ptm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ptm_pkg::rsp_type rsp_data
);
   import ptm_pkg::*;
`include "process_table_mlfq_levels_assert.svh"

   `PTM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `PTM_ASSERT_IMPL(a_rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_data))
   `PTM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `PTM_ASSERT_IMPL(a_code_level, clock, reset, rsp_valid && rsp_data.result_code != RC_OK, rsp_data.result_level == 3'd0)

endmodule

bind process_table_mlfq_levels ptm_checker u_ptm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
